// ----- rtl/core/pls_pkg.sv -----
package pls_pkg;

  // default fraction width of the fixed point format
  localparam int FRAC_BITS_DEF = 16;

  // golden section offset factor (2 - phi) in Q0.32
  localparam logic [32:0] GOLD_Q32 = 33'd1640531527;

  // configuration register indexes and reset values
  localparam logic [1:0] REG_EPSILON   = 2'd0;
  localparam logic [1:0] REG_MAX_EVALS = 2'd1;
  localparam logic [1:0] REG_FLAT_TOL  = 2'd2;
  localparam logic [30:0] EPS_RESET    = 31'd1;
  localparam logic [9:0]  MAXE_RESET   = 10'd20;
  localparam logic [9:0]  MAXE_MIN     = 10'd4;
  localparam logic [30:0] FLAT_RESET   = 31'd1;

  // result kinds
  localparam logic [1:0] KIND_EVAL  = 2'd0;
  localparam logic [1:0] KIND_FINAL = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;
  localparam logic [1:0] KIND_UNEXP = 2'd3;

  typedef struct packed {
    logic               action;
    logic signed [31:0] left_point;
    logic signed [31:0] middle_point;
    logic signed [31:0] right_point;
    logic signed [31:0] func_value;
  } pls_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] point;
    logic signed [31:0] best_value;
  } pls_result_t;

  typedef struct packed {
    logic [30:0] epsilon;
    logic [9:0]  max_evaluations;
    logic [30:0] flat_tolerance;
  } pls_cfg_t;

  // datapath operations
  typedef logic [4:0] pls_op_t;
  localparam pls_op_t DP_NOP   = 5'd0;
  localparam pls_op_t DP_START = 5'd1;
  localparam pls_op_t DP_CACHE = 5'd2;
  localparam pls_op_t DP_REQ   = 5'd3;
  localparam pls_op_t DP_HIT   = 5'd4;
  localparam pls_op_t DP_SETV  = 5'd5;
  localparam pls_op_t DP_SETGV = 5'd6;
  localparam pls_op_t DP_SWAP  = 5'd7;
  localparam pls_op_t DP_DIV   = 5'd8;
  localparam pls_op_t DP_DSAVE = 5'd9;
  localparam pls_op_t DP_MUL   = 5'd10;
  localparam pls_op_t DP_BSAVE = 5'd11;
  localparam pls_op_t DP_GINIT = 5'd12;
  localparam pls_op_t DP_MERGE = 5'd13;
  localparam pls_op_t DP_GSHUF = 5'd14;
  localparam pls_op_t DP_GSET  = 5'd15;
  localparam pls_op_t DP_EMIT  = 5'd16;

  // request point sources
  localparam logic [2:0] RSRC_P0  = 3'd0;
  localparam logic [2:0] RSRC_P1  = 3'd1;
  localparam logic [2:0] RSRC_P2  = 3'd2;
  localparam logic [2:0] RSRC_GP0 = 3'd3;
  localparam logic [2:0] RSRC_GP1 = 3'd4;
  localparam logic [2:0] RSRC_X   = 3'd5;

  // divider jobs
  localparam logic [2:0] DSEL_D1 = 3'd0;
  localparam logic [2:0] DSEL_D2 = 3'd1;
  localparam logic [2:0] DSEL_A  = 3'd2;
  localparam logic [2:0] DSEL_X  = 3'd3;

  // multiplier jobs
  localparam logic [2:0] MSEL_B  = 3'd0;
  localparam logic [2:0] MSEL_G  = 3'd1;
  localparam logic [2:0] MSEL_GL = 3'd2;

  // result payload sources
  localparam logic [2:0] ESRC_ZERO  = 3'd0;
  localparam logic [2:0] ESRC_PEND  = 3'd1;
  localparam logic [2:0] ESRC_BEST3 = 3'd2;
  localparam logic [2:0] ESRC_GOLD  = 3'd3;

  typedef struct packed {
    logic       take;
    pls_op_t    op;
    logic [2:0] sel;
    logic [1:0] kind;
  } pls_cmd_t;

  typedef struct packed {
    logic action;
    logic bracket_ok;
    logic hit;
    logic width_small;
    logic eval_done;
    logic degen;
    logic flat;
    logic vertex_in;
    logic few_left;
    logic stop;
    logic gl_go;
    logic dir;
    logic div_busy;
    logic mul_busy;
    logic out_free;
    logic out_valid;
  } pls_sts_t;

  function automatic logic signed [33:0] ext34(input logic signed [31:0] v);
    ext34 = $signed({{2{v[31]}}, v});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -72'sd2147483648) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ----- rtl/core/pls_div.sv -----
module pls_div #(
  parameter int FRAC_BITS = pls_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [33:0] num,
  input  logic signed [33:0] den,
  output logic               busy,
  output logic signed [31:0] quo
);

  localparam int NW = 33 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd;
  logic [NW-1:0] qmag;
  logic [32:0]   dsr;
  logic [33:0]   rem;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [33:0]   nabs;
  logic [33:0]   dabs;
  logic [33:0]   trial;
  logic          qbit;
  logic          hi_nz;

  assign nabs  = num[33] ? 34'(-num) : 34'(num);
  assign dabs  = den[33] ? 34'(-den) : 34'(den);
  assign trial = {rem[32:0], dvd[NW-1]};
  assign qbit  = (trial >= {1'b0, dsr});

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
      dvd  <= {nabs[32:0], {FRAC_BITS{1'b0}}};
      dsr  <= dabs[32:0];
      rem  <= '0;
      neg  <= num[33] ^ den[33];
    end else if (busy) begin
      rem  <= qbit ? (trial - {1'b0, dsr}) : trial;
      dvd  <= {dvd[NW-2:0], 1'b0};
      qmag <= {qmag[NW-2:0], qbit};
      cnt  <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // signed result with saturation to 32 bits
  assign hi_nz = |qmag[NW-1:32];
  always_comb begin
    if (neg) begin
      if (hi_nz || (qmag[31] && (|qmag[30:0]))) begin
        quo = 32'sh8000_0000;
      end else begin
        quo = 32'(-qmag[31:0]);
      end
    end else begin
      if (hi_nz || qmag[31]) begin
        quo = 32'sh7FFF_FFFF;
      end else begin
        quo = qmag[31:0];
      end
    end
  end

endmodule

// ----- rtl/core/pls_mul.sv -----
module pls_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] a,
  input  logic [32:0] b,
  output logic        busy,
  output logic [65:0] prod
);

  localparam int MW = 33;
  localparam int CW = $clog2(MW + 1);

  logic [33:0]   hi;
  logic [32:0]   lo;
  logic [32:0]   ma;
  logic [CW-1:0] cnt;
  logic [33:0]   sum;

  assign sum  = hi + (lo[0] ? {1'b0, ma} : 34'd0);
  assign prod = {hi[32:0], lo};

  // shift and add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(MW);
      hi   <= '0;
      lo   <= b;
      ma   <= a;
    end else if (busy) begin
      hi  <= {1'b0, sum[33:1]};
      lo  <= {sum[0], lo[32:1]};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/pls_dp.sv -----
module pls_dp #(
  parameter int FRAC_BITS = pls_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pls_pkg::pls_cmd_t   cmd,
  input  pls_pkg::pls_cfg_t   cfg,
  input  pls_pkg::pls_item_t  item,
  input  logic                result_ready,
  output logic                result_valid,
  output pls_pkg::pls_result_t result,
  output pls_pkg::pls_sts_t   sts
);

  pls_pkg::pls_item_t in_r;
  logic signed [31:0] v;
  logic signed [31:0] p0, p1, p2;
  logic signed [31:0] f0, f1, f2;
  logic signed [31:0] gb0, gb1, gp0, gp1, gv0, gv1;
  logic signed [31:0] pend;
  logic [9:0]         evc;
  logic signed [31:0] cp, cv;
  logic               cval;
  logic signed [31:0] d1, d2, aa, bb, xv;
  logic               mneg;
  logic               stop;
  logic               dir;

  logic signed [33:0] div_num, div_den;
  logic               div_busy, mul_busy;
  logic signed [31:0] quo;
  logic [32:0]        mul_a, mul_b;
  logic               mul_neg;
  logic [65:0]        prod;
  logic [31:0]        off;
  logic signed [71:0] tprod;
  logic signed [71:0] bsig;
  logic signed [33:0] s01, aext, w20, wg, dd;
  logic [33:0]        s01_abs, a_abs, wg_abs, dd_abs;
  logic signed [31:0] req_pt;
  logic signed [10:0] left;
  logic signed [31:0] b3_pt, b3_val;

  // shared arithmetic units
  pls_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(cmd.op == pls_pkg::DP_DIV),
    .num(div_num), .den(div_den), .busy(div_busy), .quo(quo)
  );

  pls_mul u_mul (
    .clk(clk), .rst(rst), .start(cmd.op == pls_pkg::DP_MUL),
    .a(mul_a), .b(mul_b), .busy(mul_busy), .prod(prod)
  );

  // operand selection for the divider
  always_comb begin
    unique case (cmd.sel)
      pls_pkg::DSEL_D1: begin
        div_num = pls_pkg::ext34(f1) - pls_pkg::ext34(f0);
        div_den = pls_pkg::ext34(p1) - pls_pkg::ext34(p0);
      end
      pls_pkg::DSEL_D2: begin
        div_num = pls_pkg::ext34(f2) - pls_pkg::ext34(f1);
        div_den = pls_pkg::ext34(p2) - pls_pkg::ext34(p1);
      end
      pls_pkg::DSEL_A: begin
        div_num = pls_pkg::ext34(d2) - pls_pkg::ext34(d1);
        div_den = pls_pkg::ext34(p2) - pls_pkg::ext34(p0);
      end
      default: begin
        div_num = 34'sd0 - pls_pkg::ext34(bb);
        div_den = pls_pkg::ext34(aa) + pls_pkg::ext34(aa);
      end
    endcase
  end

  // operand selection for the multiplier
  assign s01     = pls_pkg::ext34(p0) + pls_pkg::ext34(p1);
  assign s01_abs = s01[33] ? 34'(-s01) : 34'(s01);
  assign aext    = pls_pkg::ext34(aa);
  assign a_abs   = aext[33] ? 34'(-aext) : 34'(aext);
  assign w20     = pls_pkg::ext34(p2) - pls_pkg::ext34(p0);
  assign wg      = pls_pkg::ext34(gb1) - pls_pkg::ext34(gb0);
  assign wg_abs  = wg[33] ? 34'(-wg) : 34'(wg);

  always_comb begin
    mul_neg = 1'b0;
    unique case (cmd.sel)
      pls_pkg::MSEL_B: begin
        mul_a   = a_abs[32:0];
        mul_b   = s01_abs[32:0];
        mul_neg = aext[33] ^ s01[33];
      end
      pls_pkg::MSEL_G: begin
        mul_a = w20[33] ? 33'd0 : w20[32:0];
        mul_b = pls_pkg::GOLD_Q32;
      end
      default: begin
        mul_a = wg[33] ? 33'd0 : wg[32:0];
        mul_b = pls_pkg::GOLD_Q32;
      end
    endcase
  end

  // product post processing
  assign off   = prod[63:32];
  assign tprod = $signed({6'd0, prod >> FRAC_BITS});
  assign bsig  = mneg ? -tprod : tprod;

  // request point selection
  always_comb begin
    unique case (cmd.sel)
      pls_pkg::RSRC_P0:  req_pt = p0;
      pls_pkg::RSRC_P1:  req_pt = p1;
      pls_pkg::RSRC_P2:  req_pt = p2;
      pls_pkg::RSRC_GP0: req_pt = gp0;
      pls_pkg::RSRC_GP1: req_pt = gp1;
      default:           req_pt = xv;
    endcase
  end

  // best of the three sorted points
  always_comb begin
    if (f0 <= f1 && f0 <= f2) begin
      b3_pt  = p0;
      b3_val = f0;
    end else if (f1 <= f2) begin
      b3_pt  = p1;
      b3_val = f1;
    end else begin
      b3_pt  = p2;
      b3_val = f2;
    end
  end

  assign dd     = pls_pkg::ext34(p1) - pls_pkg::ext34(pend);
  assign dd_abs = dd[33] ? 34'(-dd) : 34'(dd);

  // search state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cval <= 1'b0;
    end else begin
      if (cmd.take) begin
        in_r <= item;
      end
      unique case (cmd.op)
        pls_pkg::DP_START: begin
          p0  <= in_r.left_point;
          p1  <= in_r.middle_point;
          p2  <= in_r.right_point;
          f0  <= '0;
          f1  <= '0;
          f2  <= '0;
          evc <= '0;
        end
        pls_pkg::DP_CACHE: begin
          v    <= in_r.func_value;
          cp   <= pend;
          cv   <= in_r.func_value;
          cval <= 1'b1;
        end
        pls_pkg::DP_REQ: begin
          pend <= req_pt;
          if (evc != 10'h3FF) begin
            evc <= evc + 1'b1;
          end
        end
        pls_pkg::DP_HIT: v <= cv;
        pls_pkg::DP_SETV: begin
          if (cmd.sel == 3'd0) begin
            f0 <= v;
          end else if (cmd.sel == 3'd1) begin
            f1 <= v;
          end else begin
            f2 <= v;
          end
        end
        pls_pkg::DP_SETGV: begin
          if (cmd.sel == 3'd0) begin
            gv0 <= v;
          end else begin
            gv1 <= v;
          end
        end
        pls_pkg::DP_SWAP: begin
          if (cmd.sel == 3'd0) begin
            if (p0 > p1) begin
              p0 <= p1;
              p1 <= p0;
              f0 <= f1;
              f1 <= f0;
            end
          end else begin
            if (p1 > p2) begin
              p1 <= p2;
              p2 <= p1;
              f1 <= f2;
              f2 <= f1;
            end
          end
        end
        pls_pkg::DP_DSAVE: begin
          unique case (cmd.sel)
            pls_pkg::DSEL_D1: d1 <= quo;
            pls_pkg::DSEL_D2: d2 <= quo;
            pls_pkg::DSEL_A:  aa <= quo;
            default:          xv <= quo;
          endcase
        end
        pls_pkg::DP_MUL:   mneg <= mul_neg;
        pls_pkg::DP_BSAVE: bb <= pls_pkg::sat32($signed({{40{d1[31]}}, d1}) - bsig);
        pls_pkg::DP_GINIT: begin
          gb0 <= p0;
          gb1 <= p2;
          gp0 <= p0 + $signed(off);
          gp1 <= p2 - $signed(off);
        end
        pls_pkg::DP_MERGE: begin
          stop <= (dd_abs < {3'd0, cfg.epsilon});
          if (v < f1) begin
            if (pend > p1) begin
              p0 <= p1;
              f0 <= f1;
            end else begin
              p2 <= p1;
              f2 <= f1;
            end
            p1 <= pend;
            f1 <= v;
          end else if (f0 > f2) begin
            p0 <= pend;
            f0 <= v;
          end else begin
            p2 <= pend;
            f2 <= v;
          end
        end
        pls_pkg::DP_GSHUF: begin
          dir <= (gv0 < gv1);
          if (gv0 < gv1) begin
            gb1 <= gp1;
            gp1 <= gp0;
            gv1 <= gv0;
          end else begin
            gb0 <= gp0;
            gp0 <= gp1;
            gv0 <= gv1;
          end
        end
        pls_pkg::DP_GSET: begin
          if (dir) begin
            gp0 <= gb0 + $signed(off);
          end else begin
            gp1 <= gb1 - $signed(off);
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.op == pls_pkg::DP_EMIT) begin
      result_valid <= 1'b1;
      result.kind  <= cmd.kind;
      unique case (cmd.sel)
        pls_pkg::ESRC_PEND: begin
          result.point      <= pend;
          result.best_value <= '0;
        end
        pls_pkg::ESRC_BEST3: begin
          result.point      <= b3_pt;
          result.best_value <= b3_val;
        end
        pls_pkg::ESRC_GOLD: begin
          result.point      <= (gv0 < gv1) ? gp0 : gp1;
          result.best_value <= (gv0 < gv1) ? gv0 : gv1;
        end
        default: begin
          result.point      <= '0;
          result.best_value <= '0;
        end
      endcase
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // status back to the controller
  assign left = $signed({1'b0, cfg.max_evaluations}) - $signed({1'b0, evc});

  assign sts.action      = in_r.action;
  assign sts.bracket_ok  = (in_r.left_point < in_r.middle_point) &&
                           (in_r.middle_point < in_r.right_point);
  assign sts.hit         = cval && (cp == pend);
  assign sts.width_small = (w20 < $signed({3'd0, cfg.epsilon}));
  assign sts.eval_done   = (evc >= cfg.max_evaluations);
  assign sts.degen       = (p0 == p1) || (p1 == p2) || (p0 == p2);
  assign sts.flat        = (a_abs < {3'd0, cfg.flat_tolerance});
  assign sts.vertex_in   = (xv > p0) && (xv < p2);
  assign sts.few_left    = (left <= 11'sd3);
  assign sts.stop        = stop;
  assign sts.gl_go       = (wg_abs > {3'd0, cfg.epsilon}) &&
                           (evc < cfg.max_evaluations);
  assign sts.dir         = dir;
  assign sts.div_busy    = div_busy;
  assign sts.mul_busy    = mul_busy;
  assign sts.out_free    = !result_valid || result_ready;
  assign sts.out_valid   = result_valid;

endmodule

// ----- rtl/core/pls_ctrl.sv -----
module pls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  pls_pkg::pls_sts_t sts,
  output pls_pkg::pls_cmd_t cmd
);

  // sequencer states
  localparam logic [4:0] S_WAIT  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_REQ   = 5'd2;
  localparam logic [4:0] S_CHK   = 5'd3;
  localparam logic [4:0] S_RUN   = 5'd4;
  localparam logic [4:0] S_PSTOP = 5'd5;
  localparam logic [4:0] S_SORT0 = 5'd6;
  localparam logic [4:0] S_SORT1 = 5'd7;
  localparam logic [4:0] S_SORT2 = 5'd8;
  localparam logic [4:0] S_TEST  = 5'd9;
  localparam logic [4:0] S_DIV   = 5'd10;
  localparam logic [4:0] S_DIVW  = 5'd11;
  localparam logic [4:0] S_FLAT  = 5'd12;
  localparam logic [4:0] S_MULW  = 5'd13;
  localparam logic [4:0] S_VCHK  = 5'd14;
  localparam logic [4:0] S_FALL  = 5'd15;
  localparam logic [4:0] S_GLOOP = 5'd16;
  localparam logic [4:0] S_GMUL  = 5'd17;
  localparam logic [4:0] S_EMIT  = 5'd18;

  // search phase: what the next value beat belongs to
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_A    = 4'd1;
  localparam logic [3:0] PH_B    = 4'd2;
  localparam logic [3:0] PH_C    = 4'd3;
  localparam logic [3:0] PH_PARA = 4'd4;
  localparam logic [3:0] PH_G1   = 4'd5;
  localparam logic [3:0] PH_G2   = 4'd6;
  localparam logic [3:0] PH_GL1  = 4'd7;
  localparam logic [3:0] PH_GL2  = 4'd8;

  logic [4:0] state, state_next;
  logic [3:0] phase, phase_next;
  logic [2:0] rsel, rsel_next;
  logic [3:0] rph, rph_next;
  logic [2:0] dsel, dsel_next;
  logic [2:0] msel, msel_next;
  logic [1:0] ekind, ekind_next;
  logic [2:0] esrc, esrc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WAIT;
      phase <= PH_IDLE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
    rsel  <= rsel_next;
    rph   <= rph_next;
    dsel  <= dsel_next;
    msel  <= msel_next;
    ekind <= ekind_next;
    esrc  <= esrc_next;
  end

  assign item_ready = (state == S_WAIT);

  always_comb begin
    state_next = state;
    phase_next = phase;
    rsel_next  = rsel;
    rph_next   = rph;
    dsel_next  = dsel;
    msel_next  = msel;
    ekind_next = ekind;
    esrc_next  = esrc;
    cmd.take   = 1'b0;
    cmd.op     = pls_pkg::DP_NOP;
    cmd.sel    = '0;
    cmd.kind   = pls_pkg::KIND_EVAL;

    unique case (state)
      // wait for the next item beat
      S_WAIT: begin
        if (item_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DISP;
        end
      end

      // start, bad bracket, value or unexpected item
      S_DISP: begin
        if (!sts.action) begin
          if (!sts.bracket_ok) begin
            phase_next = PH_IDLE;
            ekind_next = pls_pkg::KIND_BAD;
            esrc_next  = pls_pkg::ESRC_ZERO;
            state_next = S_EMIT;
          end else begin
            cmd.op     = pls_pkg::DP_START;
            rsel_next  = pls_pkg::RSRC_P0;
            rph_next   = PH_A;
            state_next = S_REQ;
          end
        end else if (phase == PH_IDLE) begin
          ekind_next = pls_pkg::KIND_UNEXP;
          esrc_next  = pls_pkg::ESRC_ZERO;
          state_next = S_EMIT;
        end else begin
          cmd.op     = pls_pkg::DP_CACHE;
          state_next = S_RUN;
        end
      end

      // record the requested point and count the evaluation
      S_REQ: begin
        cmd.op     = pls_pkg::DP_REQ;
        cmd.sel    = rsel;
        phase_next = rph;
        state_next = S_CHK;
      end

      // cached value or request beat
      S_CHK: begin
        if (sts.hit) begin
          cmd.op     = pls_pkg::DP_HIT;
          state_next = S_RUN;
        end else begin
          ekind_next = pls_pkg::KIND_EVAL;
          esrc_next  = pls_pkg::ESRC_PEND;
          state_next = S_EMIT;
        end
      end

      // consume the value by phase
      S_RUN: begin
        unique case (phase)
          PH_A: begin
            cmd.op     = pls_pkg::DP_SETV;
            cmd.sel    = 3'd0;
            rsel_next  = pls_pkg::RSRC_P1;
            rph_next   = PH_B;
            state_next = S_REQ;
          end
          PH_B: begin
            cmd.op     = pls_pkg::DP_SETV;
            cmd.sel    = 3'd1;
            rsel_next  = pls_pkg::RSRC_P2;
            rph_next   = PH_C;
            state_next = S_REQ;
          end
          PH_C: begin
            cmd.op     = pls_pkg::DP_SETV;
            cmd.sel    = 3'd2;
            state_next = S_SORT0;
          end
          PH_PARA: begin
            cmd.op     = pls_pkg::DP_MERGE;
            state_next = S_PSTOP;
          end
          PH_G1: begin
            cmd.op     = pls_pkg::DP_SETGV;
            cmd.sel    = 3'd0;
            rsel_next  = pls_pkg::RSRC_GP1;
            rph_next   = PH_G2;
            state_next = S_REQ;
          end
          PH_G2, PH_GL2: begin
            cmd.op     = pls_pkg::DP_SETGV;
            cmd.sel    = 3'd1;
            state_next = S_GLOOP;
          end
          PH_GL1: begin
            cmd.op     = pls_pkg::DP_SETGV;
            cmd.sel    = 3'd0;
            state_next = S_GLOOP;
          end
          default: begin
            phase_next = PH_IDLE;
            ekind_next = pls_pkg::KIND_UNEXP;
            esrc_next  = pls_pkg::ESRC_ZERO;
            state_next = S_EMIT;
          end
        endcase
      end

      // step stop after a parabolic point is merged
      S_PSTOP: begin
        if (sts.stop) begin
          phase_next = PH_IDLE;
          ekind_next = pls_pkg::KIND_FINAL;
          esrc_next  = pls_pkg::ESRC_BEST3;
          state_next = S_EMIT;
        end else begin
          state_next = S_SORT0;
        end
      end

      // three compare and swap steps
      S_SORT0: begin
        cmd.op     = pls_pkg::DP_SWAP;
        cmd.sel    = 3'd0;
        state_next = S_SORT1;
      end
      S_SORT1: begin
        cmd.op     = pls_pkg::DP_SWAP;
        cmd.sel    = 3'd1;
        state_next = S_SORT2;
      end
      S_SORT2: begin
        cmd.op     = pls_pkg::DP_SWAP;
        cmd.sel    = 3'd0;
        state_next = S_TEST;
      end

      // stop tests, then parabola fit or fallback
      S_TEST: begin
        if (sts.width_small || sts.eval_done) begin
          phase_next = PH_IDLE;
          ekind_next = pls_pkg::KIND_FINAL;
          esrc_next  = pls_pkg::ESRC_BEST3;
          state_next = S_EMIT;
        end else if (sts.degen) begin
          state_next = S_FALL;
        end else begin
          dsel_next  = pls_pkg::DSEL_D1;
          state_next = S_DIV;
        end
      end

      S_DIV: begin
        cmd.op     = pls_pkg::DP_DIV;
        cmd.sel    = dsel;
        state_next = S_DIVW;
      end

      S_DIVW: begin
        if (!sts.div_busy) begin
          cmd.op  = pls_pkg::DP_DSAVE;
          cmd.sel = dsel;
          unique case (dsel)
            pls_pkg::DSEL_D1: begin
              dsel_next  = pls_pkg::DSEL_D2;
              state_next = S_DIV;
            end
            pls_pkg::DSEL_D2: begin
              dsel_next  = pls_pkg::DSEL_A;
              state_next = S_DIV;
            end
            pls_pkg::DSEL_A: state_next = S_FLAT;
            default:         state_next = S_VCHK;
          endcase
        end
      end

      // curvature test, then the product for the linear term
      S_FLAT: begin
        if (sts.flat) begin
          state_next = S_FALL;
        end else begin
          cmd.op     = pls_pkg::DP_MUL;
          cmd.sel    = pls_pkg::MSEL_B;
          msel_next  = pls_pkg::MSEL_B;
          state_next = S_MULW;
        end
      end

      S_MULW: begin
        if (!sts.mul_busy) begin
          unique case (msel)
            pls_pkg::MSEL_B: begin
              cmd.op     = pls_pkg::DP_BSAVE;
              dsel_next  = pls_pkg::DSEL_X;
              state_next = S_DIV;
            end
            pls_pkg::MSEL_G: begin
              cmd.op     = pls_pkg::DP_GINIT;
              rsel_next  = pls_pkg::RSRC_GP0;
              rph_next   = PH_G1;
              state_next = S_REQ;
            end
            default: begin
              cmd.op     = pls_pkg::DP_GSET;
              rsel_next  = sts.dir ? pls_pkg::RSRC_GP0 : pls_pkg::RSRC_GP1;
              rph_next   = sts.dir ? PH_GL1 : PH_GL2;
              state_next = S_REQ;
            end
          endcase
        end
      end

      // vertex must lie strictly inside the bracket
      S_VCHK: begin
        if (sts.vertex_in) begin
          rsel_next  = pls_pkg::RSRC_X;
          rph_next   = PH_PARA;
          state_next = S_REQ;
        end else begin
          state_next = S_FALL;
        end
      end

      // golden section fallback
      S_FALL: begin
        if (sts.few_left) begin
          phase_next = PH_IDLE;
          ekind_next = pls_pkg::KIND_FINAL;
          esrc_next  = pls_pkg::ESRC_BEST3;
          state_next = S_EMIT;
        end else begin
          cmd.op     = pls_pkg::DP_MUL;
          cmd.sel    = pls_pkg::MSEL_G;
          msel_next  = pls_pkg::MSEL_G;
          state_next = S_MULW;
        end
      end

      // golden loop: narrow the interval or finish
      S_GLOOP: begin
        if (sts.gl_go) begin
          cmd.op     = pls_pkg::DP_GSHUF;
          state_next = S_GMUL;
        end else begin
          phase_next = PH_IDLE;
          ekind_next = pls_pkg::KIND_FINAL;
          esrc_next  = pls_pkg::ESRC_GOLD;
          state_next = S_EMIT;
        end
      end

      S_GMUL: begin
        cmd.op     = pls_pkg::DP_MUL;
        cmd.sel    = pls_pkg::MSEL_GL;
        msel_next  = pls_pkg::MSEL_GL;
        state_next = S_MULW;
      end

      // hand the result beat to the output register
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op     = pls_pkg::DP_EMIT;
          cmd.sel    = esrc;
          cmd.kind   = ekind;
          state_next = S_WAIT;
        end
      end

      default: state_next = S_WAIT;
    endcase
  end

  // no arithmetic unit runs while an item beat can be taken
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> (!sts.div_busy && !sts.mul_busy))
    else $error("arithmetic unit busy while waiting for an item");

  // a loaded result beat is visible on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == pls_pkg::DP_EMIT) |=> sts.out_valid)
    else $error("result beat lost");

  // every non-request result ends the search
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && ekind != pls_pkg::KIND_EVAL) |-> (phase == PH_IDLE))
    else $error("search still running after a final result");

  // a request result always leaves a phase that expects a value
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && ekind == pls_pkg::KIND_EVAL) |-> (phase != PH_IDLE))
    else $error("request issued with no search running");

endmodule

// ----- rtl/core/parabolic_line_search.sv -----
// parabolic_line_search: one-variable minimizer in signed fixed point.
// item channel (item_valid/item_ready/item): action 0 starts a search with a
// bracket left < middle < right, action 1 returns f at the last requested
// point. result channel (result_valid/result_ready/result): every item beat
// gives exactly one result beat: an evaluate request, the final minimum, a
// bad bracket or an unexpected item.
// apb port: epsilon at 0x0, max_evaluations at 0x4, flat_tolerance at 0x8;
// zero or out-of-range writes keep the old value. write only while idle.
// a golden section step runs one product through the shift-add multiplier,
// and a parabolic step makes four passes through the radix-2 divider plus
// one multiply.
// one item is worked at a time; item_ready is high only while waiting.
// reset clears the config registers to their defaults, empties the value
// cache and returns to idle. when result_ready is low the finished beat
// stays in the output register; a new item can still be taken, and its
// result waits until the register frees.
module parabolic_line_search #(
  parameter int FRAC_BITS = pls_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  pls_pkg::pls_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output pls_pkg::pls_result_t result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  pls_pkg::pls_cfg_t cfg;
  pls_pkg::pls_cmd_t cmd;
  pls_pkg::pls_sts_t sts;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.epsilon         <= pls_pkg::EPS_RESET;
      cfg.max_evaluations <= pls_pkg::MAXE_RESET;
      cfg.flat_tolerance  <= pls_pkg::FLAT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        pls_pkg::REG_EPSILON: begin
          if (pwdata[30:0] != '0) begin
            cfg.epsilon <= pwdata[30:0];
          end
        end
        pls_pkg::REG_MAX_EVALS: begin
          if (pwdata[9:0] >= pls_pkg::MAXE_MIN) begin
            cfg.max_evaluations <= pwdata[9:0];
          end
        end
        pls_pkg::REG_FLAT_TOL: begin
          if (pwdata[30:0] != '0) begin
            cfg.flat_tolerance <= pwdata[30:0];
          end
        end
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      pls_pkg::REG_EPSILON:   prdata = {1'b0, cfg.epsilon};
      pls_pkg::REG_MAX_EVALS: prdata = {22'd0, cfg.max_evaluations};
      pls_pkg::REG_FLAT_TOL:  prdata = {1'b0, cfg.flat_tolerance};
      default:                prdata = '0;
    endcase
  end

  pls_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .sts(sts), .cmd(cmd)
  );

  pls_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .cfg(cfg), .item(item),
    .result_ready(result_ready), .result_valid(result_valid),
    .result(result), .sts(sts)
  );

endmodule
